// ===== src/ggbu_pkg.sv =====
// ----------------------------------------------------------------------------
// ggbu_pkg
// Shared types, codes and widths of the gaussian gradient bandit update block.
// ----------------------------------------------------------------------------
package ggbu_pkg;

  localparam int ACT_DIMS  = 8;
  localparam int FRAC_BITS = 16;
  localparam int DIM_W     = 3;

  localparam logic [31:0] SPREAD_ONE = 32'(64'd1 << FRAC_BITS);
  localparam logic [30:0] LR_RESET   = 31'd655;

  // serial multiplier: MUL_W x MUL_W operands, one multiplier bit a cycle
  localparam int MUL_W  = 64;
  localparam int MUL_CW = $clog2(MUL_W);
  // serial divider: DIV_W dividend, 32-bit divisor, one quotient bit a cycle
  localparam int DIV_W  = 128;
  localparam int DIV_CW = $clog2(DIV_W);

  // gradient step magnitudes clamp here
  localparam logic [33:0] MAG_CLAMP = 34'h2_0000_0000;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_UPDATE = 2'd1;
  localparam logic [1:0] MODE_READ   = 2'd2;
  // unused code, behaves as read
  localparam logic [1:0] MODE_RSVD   = 2'd3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SAT   = 2'd1;
  localparam logic [1:0] STATUS_BADSG = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [DIM_W-1:0]  dimension;
    logic              first_of_update;
    logic signed [31:0] reward;
    logic signed [31:0] action_value;
    logic signed [31:0] param_mean;
    logic signed [31:0] param_spread;
  } in_item_t;

  typedef struct packed {
    logic [DIM_W-1:0]  out_dimension;
    logic signed [31:0] new_mean;
    logic signed [31:0] new_spread;
    logic signed [31:0] advantage_out;
    logic [1:0]        status;
  } out_item_t;

  // handshake between the sequencer and a serial arithmetic unit
  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

  // quotient clamped to the largest step magnitude
  function automatic logic [33:0] clamp_mag(input logic [DIV_W-1:0] q);
    logic [33:0] r;
    if (|q[DIV_W-1:33]) begin
      r = MAG_CLAMP;
    end else begin
      r = q[33:0];
    end
    return r;
  endfunction

endpackage

// ===== src/gaussian_gradient_bandit_update_top.sv =====
// ----------------------------------------------------------------------------
// gaussian_gradient_bandit_update_top
// Gaussian policy gradient bandit update, one action dimension per word.
//
// channel | signals                          | word
// in      | in_valid_i / in_ready_o          | in_item_t  in_data_i
// out     | out_valid_o / out_ready_i        | out_item_t out_data_o
// cfg     | cfg_valid_i / cfg_ready_o        | learning rate, 31 bits
//
// load and read words use no arithmetic unit; update words run five serial
// multiplies and five serial divisions, plus one more division for the
// running reward on the first word of an update.
// the serial divider sets the pace. one word is in work at a time; a new
// word is taken while the previous result waits in the output register.
// reset restores all stores at once, no clearing pass.
// ----------------------------------------------------------------------------
module gaussian_gradient_bandit_update_top import ggbu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [30:0] cfg_data_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_FIRST, ST_DIV_RR, ST_ADV, ST_SIG, ST_SQ_S, ST_SQ_D, ST_MUL_P,
    ST_MUL_M, ST_DIV_M, ST_MUL_E, ST_DIV_E, ST_APPLY, ST_FIN
  } state_e;

  state_e             state_q;
  in_item_t           item_q;
  out_item_t          out_q;
  logic               out_valid_q;
  logic [30:0]        lr_q;
  logic signed [31:0] mean_q [ACT_DIMS];
  logic signed [31:0] spread_q [ACT_DIMS];
  logic [31:0]        cnt_q;
  logic signed [31:0] rr_q;
  logic signed [31:0] adv_q;
  logic               sat_q;
  logic               bad_q;
  logic               rneg_q;
  logic               dneg_q;
  logic               aneg_q;
  logic               eneg_q;
  logic [31:0]        dmag_q;
  logic [31:0]        amag_q;
  logic [63:0]        s2_q;
  logic [63:0]        emag_q;
  logic [63:0]        p_q;
  logic [33:0]        mm_q;
  logic [33:0]        sm_q;
  logic [1:0]         pass_q;

  logic [MUL_W-1:0]   mul_a_q;
  logic [MUL_W-1:0]   mul_b_q;
  logic [DIV_W-1:0]   div_a_q;
  logic [31:0]        div_b_q;
  unit_ctl_t          mul_ctl;
  unit_ctl_t          div_ctl;
  logic               mul_start_q;
  logic               div_start_q;
  logic [2*MUL_W-1:0] mul_p;
  logic [DIV_W-1:0]   div_q;

  // combinational helpers
  logic [31:0]        cnt_inc;
  logic signed [32:0] rr_diff;
  logic [32:0]        rr_dmag;
  logic signed [33:0] rr_step;
  logic signed [33:0] rr_sum;
  logic signed [32:0] adv_raw;
  logic signed [32:0] dv;
  logic [32:0]        dv_mag;
  logic [31:0]        adv_mag;
  logic [63:0]        d2;
  logic signed [34:0] mean_sum;
  logic signed [34:0] spread_sum;
  logic               mean_hi, mean_lo, spread_hi, spread_lo;
  logic [DIM_W-1:0]   dim;
  logic [31:0]        sig_u;

  assign dim   = item_q.dimension;
  assign sig_u = item_q.param_spread;

  assign cnt_inc = (cnt_q == 32'hFFFF_FFFF) ? cnt_q : cnt_q + 32'd1;
  assign rr_diff = 33'(item_q.reward) - 33'(rr_q);
  assign rr_dmag = rr_diff[32] ? 33'(-rr_diff) : rr_diff;
  assign rr_step = rneg_q ? -$signed({1'b0, div_q[32:0]}) : $signed({1'b0, div_q[32:0]});
  assign rr_sum  = 34'(rr_q) + rr_step;
  assign adv_raw = 33'(item_q.reward) - 33'(rr_q);
  assign dv      = 33'(item_q.action_value) - 33'(item_q.param_mean);
  assign dv_mag  = dv[32] ? 33'(-dv) : dv;
  assign adv_mag = adv_q[31] ? 32'(-33'(adv_q)) : adv_q;
  assign d2      = mul_p[63:0];

  assign mean_sum = 35'(mean_q[dim]) +
                    ((dneg_q != aneg_q) ? -$signed({1'b0, mm_q}) : $signed({1'b0, mm_q}));
  assign spread_sum = 35'(spread_q[dim]) +
                      ((eneg_q != aneg_q) ? -$signed({1'b0, sm_q}) : $signed({1'b0, sm_q}));
  assign mean_hi   = mean_sum > 35'sd2147483647;
  assign mean_lo   = mean_sum < -35'sd2147483648;
  assign spread_hi = spread_sum > 35'sd2147483647;
  assign spread_lo = spread_sum < -35'sd2147483648;

  assign mul_ctl.start = mul_start_q;
  assign div_ctl.start = div_start_q;

  ggbu_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_ctl.start),
    .a_i     (mul_a_q),
    .b_i     (mul_b_q),
    .done_o  (mul_ctl.done),
    .prod_o  (mul_p)
  );

  ggbu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_ctl.start),
    .dividend_i (div_a_q),
    .divisor_i  (div_b_q),
    .done_o     (div_ctl.done),
    .quo_o      (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      lr_q        <= LR_RESET;
      cnt_q       <= '0;
      rr_q        <= '0;
      adv_q       <= '0;
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      for (int i = 0; i < ACT_DIMS; i++) begin
        mean_q[i]   <= '0;
        spread_q[i] <= SPREAD_ONE;
      end
    end else begin
      mul_start_q <= 1'b0;
      div_start_q <= 1'b0;
      if (state_q == ST_FIN && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        lr_q <= cfg_data_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q <= in_data_i;
            sat_q  <= 1'b0;
            bad_q  <= 1'b0;
            if (in_data_i.mode == MODE_UPDATE && in_data_i.first_of_update) begin
              state_q <= ST_FIRST;
            end else begin
              state_q <= ST_SIG;
            end
          end
        end
        ST_FIRST: begin
          cnt_q       <= cnt_inc;
          rneg_q      <= rr_diff[32];
          div_a_q     <= DIV_W'(rr_dmag);
          div_b_q     <= cnt_inc;
          div_start_q <= 1'b1;
          state_q     <= ST_DIV_RR;
        end
        ST_DIV_RR: begin
          if (div_ctl.done) begin
            // step lies between old mean and reward, so it never overflows
            rr_q    <= rr_sum[31:0];
            state_q <= ST_ADV;
          end
        end
        ST_ADV: begin
          if (adv_raw > 33'sd2147483647) begin
            adv_q <= 32'h7FFF_FFFF;
            sat_q <= 1'b1;
          end else if (adv_raw < -33'sd2147483648) begin
            adv_q <= 32'h8000_0000;
            sat_q <= 1'b1;
          end else begin
            adv_q <= adv_raw[31:0];
          end
          state_q <= ST_SIG;
        end
        ST_SIG: begin
          if (item_q.mode == MODE_LOAD) begin
            mean_q[dim]   <= item_q.param_mean;
            spread_q[dim] <= item_q.param_spread;
            state_q       <= ST_FIN;
          end else if (item_q.mode == MODE_UPDATE) begin
            if (item_q.param_spread[31] || item_q.param_spread == 32'sd0) begin
              bad_q   <= 1'b1;
              state_q <= ST_FIN;
            end else begin
              dneg_q      <= dv[32];
              dmag_q      <= dv_mag[31:0];
              aneg_q      <= adv_q[31];
              amag_q      <= adv_mag;
              mul_a_q     <= MUL_W'(sig_u);
              mul_b_q     <= MUL_W'(sig_u);
              mul_start_q <= 1'b1;
              state_q     <= ST_SQ_S;
            end
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_SQ_S: begin
          if (mul_ctl.done) begin
            s2_q        <= mul_p[63:0];
            mul_a_q     <= MUL_W'(dmag_q);
            mul_b_q     <= MUL_W'(dmag_q);
            mul_start_q <= 1'b1;
            state_q     <= ST_SQ_D;
          end
        end
        ST_SQ_D: begin
          if (mul_ctl.done) begin
            eneg_q      <= d2 < s2_q;
            emag_q      <= (d2 < s2_q) ? s2_q - d2 : d2 - s2_q;
            mul_a_q     <= MUL_W'(lr_q);
            mul_b_q     <= MUL_W'(amag_q);
            mul_start_q <= 1'b1;
            state_q     <= ST_MUL_P;
          end
        end
        ST_MUL_P: begin
          if (mul_ctl.done) begin
            p_q         <= mul_p[63:0];
            mul_a_q     <= mul_p[63:0];
            mul_b_q     <= MUL_W'(dmag_q);
            mul_start_q <= 1'b1;
            state_q     <= ST_MUL_M;
          end
        end
        ST_MUL_M: begin
          if (mul_ctl.done) begin
            div_a_q     <= DIV_W'(mul_p);
            div_b_q     <= sig_u;
            div_start_q <= 1'b1;
            pass_q      <= '0;
            state_q     <= ST_DIV_M;
          end
        end
        ST_DIV_M: begin
          // mean step: two divisions by sigma
          if (div_ctl.done) begin
            if (pass_q == 2'd0) begin
              div_a_q     <= div_q;
              div_start_q <= 1'b1;
              pass_q      <= 2'd1;
            end else begin
              mm_q        <= clamp_mag(div_q);
              mul_a_q     <= p_q;
              mul_b_q     <= emag_q;
              mul_start_q <= 1'b1;
              state_q     <= ST_MUL_E;
            end
          end
        end
        ST_MUL_E: begin
          if (mul_ctl.done) begin
            div_a_q     <= DIV_W'(mul_p);
            div_start_q <= 1'b1;
            pass_q      <= '0;
            state_q     <= ST_DIV_E;
          end
        end
        ST_DIV_E: begin
          // spread step: three divisions by sigma
          if (div_ctl.done) begin
            if (pass_q != 2'd2) begin
              div_a_q     <= div_q;
              div_start_q <= 1'b1;
              pass_q      <= pass_q + 2'd1;
            end else begin
              sm_q    <= clamp_mag(div_q);
              state_q <= ST_APPLY;
            end
          end
        end
        ST_APPLY: begin
          if (mean_hi) begin
            mean_q[dim] <= 32'h7FFF_FFFF;
          end else if (mean_lo) begin
            mean_q[dim] <= 32'h8000_0000;
          end else begin
            mean_q[dim] <= mean_sum[31:0];
          end
          if (spread_hi) begin
            spread_q[dim] <= 32'h7FFF_FFFF;
          end else if (spread_lo) begin
            spread_q[dim] <= 32'h8000_0000;
          end else begin
            spread_q[dim] <= spread_sum[31:0];
          end
          if (mean_hi || mean_lo || spread_hi || spread_lo) begin
            sat_q <= 1'b1;
          end
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_q.out_dimension <= dim;
            out_q.new_mean      <= mean_q[dim];
            out_q.new_spread    <= spread_q[dim];
            out_q.advantage_out <= adv_q;
            out_q.status        <= bad_q ? STATUS_BADSG : (sat_q ? STATUS_SAT : STATUS_OK);
            state_q             <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

endmodule

// ===== src/ggbu_mul.sv =====
// ----------------------------------------------------------------------------
// ggbu_mul
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module ggbu_mul import ggbu_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MUL_W-1:0]   a_i,
  input  logic [MUL_W-1:0]   b_i,
  output logic               done_o,
  output logic [2*MUL_W-1:0] prod_o
);

  logic [2*MUL_W-1:0] acc_q;
  logic [MUL_W-1:0]   mc_q;
  logic [MUL_CW-1:0]  cnt_q;
  logic               busy_q;
  logic               done_q;
  logic [MUL_W:0]     sum;

  assign sum = {1'b0, acc_q[2*MUL_W-1:MUL_W]} + (acc_q[0] ? {1'b0, mc_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == MUL_CW'(MUL_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= {{MUL_W{1'b0}}, b_i};
      mc_q  <= a_i;
    end else if (busy_q) begin
      acc_q <= {sum, acc_q[MUL_W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== src/ggbu_div.sv =====
// ----------------------------------------------------------------------------
// ggbu_div
// Restoring bit-serial divider, wide dividend by a 32-bit divisor.
// ----------------------------------------------------------------------------
module ggbu_div import ggbu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [31:0]      divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quo_o
);

  logic [DIV_W-1:0]  quo_q;
  logic [31:0]       rem_q;
  logic [31:0]       dvs_q;
  logic [DIV_CW-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [32:0]       sh;
  logic [32:0]       diff;
  logic              ge;

  assign sh   = {rem_q, quo_q[DIV_W-1]};
  assign diff = sh - {1'b0, dvs_q};
  assign ge   = sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CW'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so 32 bits hold it
      rem_q <= ge ? diff[31:0] : sh[31:0];
      quo_q <= {quo_q[DIV_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the gaussian gradient bandit update block. Drives
// load, update and read words with random gaps, predicts every result from a
// model of the policy stores, and compares each result word field by field.
// ----------------------------------------------------------------------------
module testbench;
  import ggbu_pkg::*;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int ITEMS_PER_PHASE = 170;

  class policy_scoreboard;
    longint      mean_q[ACT_DIMS];
    longint      spread_q[ACT_DIMS];
    int unsigned visits;
    longint      avg_reward;
    longint      advantage;
    longint      rate;
    out_item_t   pending[$];
    int          errors;

    function new();
      for (int i = 0; i < ACT_DIMS; i++) begin
        mean_q[i] = 0;
        spread_q[i] = longint'(SPREAD_ONE);
      end
      visits = 0;
      avg_reward = 0;
      advantage = 0;
      rate = longint'(LR_RESET);
      errors = 0;
    endfunction

    function longint clip32(longint v, inout bit sat);
      longint r;
      r = v;
      if (v > 64'sd2147483647) begin
        sat = 1'b1;
        r = 64'sd2147483647;
      end else if (v < -64'sd2147483648) begin
        sat = 1'b1;
        r = -64'sd2147483648;
      end
      return r;
    endfunction

    function longint step_by(longint base, bit neg, logic [63:0] mag, inout bit sat);
      longint d;
      if (mag > 64'h2_0000_0000) mag = 64'h2_0000_0000;
      d = neg ? -longint'(mag) : longint'(mag);
      return clip32(base + d, sat);
    endfunction

    // floor(a*b/c) with the quotient clamped to 64 bits
    function logic [63:0] scaled_quot(logic [63:0] a, logic [63:0] b, logic [63:0] c);
      logic [127:0] w;
      w = ({64'd0, a} * {64'd0, b}) / {64'd0, c};
      if (|w[127:64]) w = {64'd0, {64{1'b1}}};
      return w[63:0];
    endfunction

    function void note_word(in_item_t w);
      int          d;
      bit          sat, badsig;
      longint      rew, act, pm, ps, dv;
      bit          dneg, aneg, eneg;
      logic [63:0] dmag, amag, s, s2, p, d2, emag, mm, sm;
      out_item_t   r;
      d = int'(w.dimension);
      sat = 0;
      badsig = 0;
      rew = longint'(w.reward);
      act = longint'(w.action_value);
      pm = longint'(w.param_mean);
      ps = longint'(w.param_spread);
      if (w.mode == MODE_LOAD) begin
        mean_q[d] = pm;
        spread_q[d] = ps;
      end else if (w.mode == MODE_UPDATE) begin
        if (w.first_of_update) begin
          if (visits != 32'hFFFF_FFFF) visits++;
          avg_reward = avg_reward + (rew - avg_reward) / longint'(visits);
          avg_reward = clip32(avg_reward, sat);
          advantage = clip32(rew - avg_reward, sat);
        end
        if (ps <= 0) begin
          badsig = 1;
        end else begin
          dv = act - pm;
          dneg = dv < 0;
          aneg = advantage < 0;
          dmag = dneg ? -dv : dv;
          amag = aneg ? -advantage : advantage;
          s = ps;
          s2 = s * s;
          p = rate * amag;
          d2 = dmag * dmag;
          eneg = d2 < s2;
          emag = eneg ? s2 - d2 : d2 - s2;
          mm = scaled_quot(p, dmag, s2);
          sm = scaled_quot(p, emag, s2) / s;
          mean_q[d] = step_by(mean_q[d], dneg != aneg, mm, sat);
          spread_q[d] = step_by(spread_q[d], eneg != aneg, sm, sat);
        end
      end
      r.out_dimension = w.dimension;
      r.new_mean = mean_q[d][31:0];
      r.new_spread = spread_q[d][31:0];
      r.advantage_out = advantage[31:0];
      r.status = badsig ? STATUS_BADSG : (sat ? STATUS_SAT : STATUS_OK);
      pending.insert(pending.size(), r);
    endfunction

    function void check_word(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.out_dimension !== e.out_dimension) begin
        $error("out_dimension expected %0d actual %0d", e.out_dimension, got.out_dimension);
        errors++;
      end
      if (got.new_mean !== e.new_mean) begin
        $error("new_mean expected %0d actual %0d", e.new_mean, got.new_mean);
        errors++;
      end
      if (got.new_spread !== e.new_spread) begin
        $error("new_spread expected %0d actual %0d", e.new_spread, got.new_spread);
        errors++;
      end
      if (got.advantage_out !== e.advantage_out) begin
        $error("advantage_out expected %0d actual %0d", e.advantage_out, got.advantage_out);
        errors++;
      end
      if (got.status !== e.status) begin
        $error("status expected %0d actual %0d", e.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_data_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [30:0] cfg_data_i;

  policy_scoreboard sb;
  int  sent;
  int  quiet_cycles;
  bit  hold_done;

  gaussian_gradient_bandit_update_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  task automatic send_word(in_item_t w);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i = w;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(w);
    sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // only while the block is idle: every expected word has come back
  task automatic write_rate(logic [30:0] v);
    while (sb.pending.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.rate = longint'(v);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  function automatic in_item_t make_word(logic [1:0] m, int d, bit f, longint rw,
                                         longint a, longint pm, longint ps);
    in_item_t w;
    w.mode = m;
    w.dimension = d[DIM_W-1:0];
    w.first_of_update = f;
    w.reward = rw[31:0];
    w.action_value = a[31:0];
    w.param_mean = pm[31:0];
    w.param_spread = ps[31:0];
    return w;
  endfunction

  function automatic longint near(int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  // one well-formed update run carrying the current stored parameters
  task automatic update_run();
    int n, d0;
    n = $urandom_range(1, ACT_DIMS);
    d0 = $urandom_range(0, ACT_DIMS - 1);
    for (int i = 0; i < n; i++) begin
      int d;
      longint rw;
      d = (d0 + i) % ACT_DIMS;
      rw = ($urandom_range(0, 9) == 0) ? longint'(signed'($urandom())) : near(1 << 20);
      send_word(make_word(MODE_UPDATE, d, i == 0, rw,
                          sb.mean_q[d] + near(int'(sb.spread_q[d] > 0 ? 1 << 19 : 1 << 10)),
                          sb.mean_q[d], sb.spread_q[d]));
    end
  endtask

  task automatic random_phase(int count);
    int start;
    start = sent;
    while (sent - start < count) begin
      int k;
      k = $urandom_range(0, 99);
      if (k < 20) begin
        send_word(make_word(MODE_LOAD, $urandom_range(0, 7), $urandom_range(0, 1),
                            near(1 << 20), near(1 << 20), near(1 << 22),
                            longint'($urandom_range(1 << 12, 1 << 20))));
      end else if (k < 70) begin
        update_run();
      end else if (k < 85) begin
        send_word(make_word($urandom_range(0, 1) ? MODE_READ : MODE_RSVD, $urandom_range(0, 7),
                            $urandom_range(0, 1), 0, 0, 0, 0));
      end else begin
        in_item_t     w;
        logic [159:0] raw;
        raw = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        w = in_item_t'(raw[$bits(in_item_t)-1:0]);
        if (w.mode == MODE_LOAD && $urandom_range(0, 1)) w.param_spread = 32'sd65536;
        send_word(w);
      end
    end
  endtask

  // receiver, with one long hold-off once traffic is under way
  initial begin
    out_ready_i = 1'b0;
    hold_done = 0;
    wait (rst_ni === 1'b1);
    forever begin
      int gap;
      if (!hold_done && sent > 300) begin
        hold_done = 1;
        @(negedge clk_i);
        out_ready_i = 1'b0;
        repeat (3000) @(negedge clk_i);
      end
      gap = pick_gap();
      repeat (gap) begin
        @(negedge clk_i);
        out_ready_i = 1'b0;
      end
      @(negedge clk_i);
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_word(out_data_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    sb = new();
    sent = 0;
    quiet_cycles = 0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: default, maximum and zero rates, reads, loads of extremes, bad sigma, saturation
    send_word(make_word(MODE_READ, 0, 0, 0, 0, 0, 0));
    send_word(make_word(MODE_UPDATE, 1, 0, 0, 65536, 0, 65536));
    send_word(make_word(MODE_UPDATE, 2, 1, 32'sh7FFF_FFFF, 65536, 0, 65536));
    send_word(make_word(MODE_LOAD, 7, 1, -1, -1, 32'sh7FFF_FFFF, -32'sh8000_0000));
    send_word(make_word(MODE_RSVD, 7, 1, 0, 0, 0, 0));
    send_word(make_word(MODE_UPDATE, 7, 0, 0, 0, 0, -32'sh8000_0000));
    send_word(make_word(MODE_UPDATE, 3, 1, -32'sh8000_0000, 0, 0, 0));
    send_word(make_word(MODE_LOAD, 4, 0, 0, 0, -32'sh8000_0000, 1));
    send_word(make_word(MODE_UPDATE, 4, 0, 0, 32'sh7FFF_FFFF, -32'sh8000_0000, 1));
    send_word(make_word(MODE_UPDATE, 5, 0, 0, -32'sh8000_0000, 32'sh7FFF_FFFF,
                        32'sh7FFF_FFFF));
    write_rate(31'h7FFF_FFFF);
    send_word(make_word(MODE_UPDATE, 0, 1, 32'sh4000_0000, 1 << 17, 0, 65536));
    send_word(make_word(MODE_UPDATE, 1, 0, 0, -(1 << 17), 0, 65536));
    send_word(make_word(MODE_UPDATE, 6, 0, 0, 32'sh7FFF_FFFF, -32'sh8000_0000, 1));
    send_word(make_word(MODE_READ, 6, 0, 0, 0, 0, 0));
    write_rate(31'd0);
    send_word(make_word(MODE_UPDATE, 2, 1, -12345, 777, 0, 65536));
    send_word(make_word(MODE_READ, 2, 0, 0, 0, 0, 0));

    write_rate(LR_RESET);
    random_phase(ITEMS_PER_PHASE);
    write_rate(31'd65536);
    random_phase(ITEMS_PER_PHASE);
    write_rate(31'h7FFF_FFFF);
    random_phase(ITEMS_PER_PHASE / 2);
    write_rate(31'd0);
    random_phase(ITEMS_PER_PHASE / 2);
    write_rate(31'($urandom()));
    random_phase(ITEMS_PER_PHASE);
    write_rate(31'd6553);
    random_phase(ITEMS_PER_PHASE);

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
